/* src/srpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srpe_pkg;

   localparam int PIX_W       = 8;
   localparam int COORD_W     = 11;
   localparam int SHADE_W     = 8;
   localparam int LEVEL_W     = 9;
   localparam int OFFSET_W    = 12;
   localparam int POINT_X_W   = 12;
   localparam int POINT_Y_W   = 13;
   localparam int WIDTH_W     = 3;
   localparam int PROD_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int DIV_STEPS   = 8;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHADE_LEVELS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y     = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVELS_RESET = 9'd4;
   localparam logic [LEVEL_W-1:0] LEVELS_MIN   = 9'd1;
   localparam logic [LEVEL_W-1:0] LEVELS_MAX   = 9'd256;

   localparam logic [WIDTH_W-1:0] WIDTH_LIGHTEST = 3'd0;
   localparam logic [WIDTH_W-1:0] WIDTH_STROKE   = 3'd4;

   // effective configuration as seen by the datapath
   typedef struct packed {
      logic [LEVEL_W-1:0]         levels;
      logic signed [OFFSET_W-1:0] offset_x;
      logic [OFFSET_W-1:0]        offset_y;
   } cfg_type;

   // one queued request: the held pixel's point and/or the row-end point
   typedef struct packed {
      logic               has_held;
      logic [COORD_W-1:0] held_column;
      logic [COORD_W-1:0] held_row;
      logic [SHADE_W-1:0] held_shade;
      logic               has_cur;
      logic [COORD_W-1:0] cur_column;
      logic [COORD_W-1:0] cur_row;
      logic [SHADE_W-1:0] cur_shade;
   } point_pair_type;

endpackage

`default_nettype wire

/* src/srpe_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpe_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  push,
   output logic                                 full,
   input  wire  [srpe_pkg::PIX_W-1:0]           gray_level,
   input  wire  [srpe_pkg::PIX_W-1:0]           alpha,
   input  wire  [srpe_pkg::COORD_W-1:0]         column,
   input  wire  [srpe_pkg::COORD_W-1:0]         row,
   input  wire                                  row_end,
   input  wire  [srpe_pkg::LEVEL_W-1:0]         levels,
   input  wire                                  q_full,
   output logic                                 q_push,
   output srpe_pkg::point_pair_type             q_data
);

   // stage 1: raw pixel
   logic                          s1_valid_ff, s1_valid_in;
   logic [srpe_pkg::PIX_W-1:0]    s1_gray_ff, s1_gray_in;
   logic [srpe_pkg::PIX_W-1:0]    s1_alpha_ff, s1_alpha_in;
   logic [srpe_pkg::COORD_W-1:0]  s1_col_ff, s1_col_in;
   logic [srpe_pkg::COORD_W-1:0]  s1_row_ff, s1_row_in;
   logic                          s1_end_ff, s1_end_in;

   // stage 2: blend product, then shade and run decision
   logic                          s2_valid_ff, s2_valid_in;
   logic [srpe_pkg::PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [srpe_pkg::PIX_W-1:0]    s2_gray_ff, s2_gray_in;
   logic [srpe_pkg::COORD_W-1:0]  s2_col_ff, s2_col_in;
   logic [srpe_pkg::COORD_W-1:0]  s2_row_ff, s2_row_in;
   logic                          s2_end_ff, s2_end_in;

   // run state
   logic                          held_valid_ff, held_valid_in;
   logic [srpe_pkg::COORD_W-1:0]  held_col_ff, held_col_in;
   logic [srpe_pkg::COORD_W-1:0]  held_row_ff, held_row_in;
   logic [srpe_pkg::SHADE_W-1:0]  held_shade_ff, held_shade_in;
   logic                          prev_valid_ff, prev_valid_in;
   logic [srpe_pkg::SHADE_W-1:0]  prev_shade_ff, prev_shade_in;

   logic                          adv;
   logic                          accept;
   logic [srpe_pkg::PIX_W-1:0]    inv_gray;
   logic [srpe_pkg::PIX_W-1:0]    inv_alpha;
   logic [srpe_pkg::PROD_W-1:0]   prod;
   logic [srpe_pkg::PROD_W:0]     div_sum;
   logic [srpe_pkg::PIX_W-1:0]    blended;
   logic [srpe_pkg::PROD_W:0]     scaled;
   logic [srpe_pkg::SHADE_W-1:0]  shade;
   logic                          emit_held;
   logic                          emits;

   assign inv_gray  = 8'hFF - s1_gray_ff;
   assign inv_alpha = 8'hFF - s1_alpha_ff;
   assign prod      = srpe_pkg::PROD_W'(inv_gray) * srpe_pkg::PROD_W'(inv_alpha);

   // x/255 for x up to 255*255: (x + 1 + (x >> 8)) >> 8
   assign div_sum = (srpe_pkg::PROD_W+1)'(s2_prod_ff) + 17'd1
                  + (srpe_pkg::PROD_W+1)'(s2_prod_ff >> 8);
   // never exceeds 255: the blend term is at most 255 - gray
   assign blended = s2_gray_ff + div_sum[15:8];
   assign scaled  = (srpe_pkg::PROD_W+1)'(blended) * (srpe_pkg::PROD_W+1)'(levels);
   assign shade   = scaled[15:8];

   assign emit_held = held_valid_ff &&
                      (!prev_valid_ff || (prev_shade_ff != held_shade_ff) ||
                       (shade != held_shade_ff));
   assign emits     = emit_held || s2_end_ff;

   assign adv    = !s2_valid_ff || !emits || !q_full;
   assign full   = !adv;
   assign accept = push && adv;
   assign q_push = s2_valid_ff && emits && !q_full;

   always_comb begin
      q_data.has_held    = emit_held;
      q_data.held_column = held_col_ff;
      q_data.held_row    = held_row_ff;
      q_data.held_shade  = held_shade_ff;
      q_data.has_cur     = s2_end_ff;
      q_data.cur_column  = s2_col_ff;
      q_data.cur_row     = s2_row_ff;
      q_data.cur_shade   = shade;
   end

   always_comb begin
      s1_valid_in = adv ? accept : s1_valid_ff;
      s1_gray_in  = accept ? gray_level : s1_gray_ff;
      s1_alpha_in = accept ? alpha : s1_alpha_ff;
      s1_col_in   = accept ? column : s1_col_ff;
      s1_row_in   = accept ? row : s1_row_ff;
      s1_end_in   = accept ? row_end : s1_end_ff;

      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s2_prod_in  = adv ? prod : s2_prod_ff;
      s2_gray_in  = adv ? s1_gray_ff : s2_gray_ff;
      s2_col_in   = adv ? s1_col_ff : s2_col_ff;
      s2_row_in   = adv ? s1_row_ff : s2_row_ff;
      s2_end_in   = adv ? s1_end_ff : s2_end_ff;

      held_valid_in = held_valid_ff;
      held_col_in   = held_col_ff;
      held_row_in   = held_row_ff;
      held_shade_in = held_shade_ff;
      prev_valid_in = prev_valid_ff;
      prev_shade_in = prev_shade_ff;

      if (s2_valid_ff && adv) begin
         if (emit_held) begin
            prev_valid_in = 1'b1;
            prev_shade_in = held_shade_ff;
         end
         if (s2_end_ff) begin
            // row closed: nothing held, no shade emitted yet
            held_valid_in = 1'b0;
            prev_valid_in = 1'b0;
            prev_shade_in = '0;
         end else begin
            held_valid_in = 1'b1;
            held_col_in   = s2_col_ff;
            held_row_in   = s2_row_ff;
            held_shade_in = shade;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         held_valid_ff <= held_valid_in;
         prev_valid_ff <= prev_valid_in;
      end
      s1_gray_ff    <= s1_gray_in;
      s1_alpha_ff   <= s1_alpha_in;
      s1_col_ff     <= s1_col_in;
      s1_row_ff     <= s1_row_in;
      s1_end_ff     <= s1_end_in;
      s2_prod_ff    <= s2_prod_in;
      s2_gray_ff    <= s2_gray_in;
      s2_col_ff     <= s2_col_in;
      s2_row_ff     <= s2_row_in;
      s2_end_ff     <= s2_end_in;
      held_col_ff   <= held_col_in;
      held_row_ff   <= held_row_in;
      held_shade_ff <= held_shade_in;
      prev_shade_ff <= prev_shade_in;
   end

endmodule

`default_nettype wire

/* src/srpe_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpe_queue #(
   parameter int DEPTH = srpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  srpe_pkg::point_pair_type  push_data,
   output logic                      full,
   input  wire                       pop,
   output srpe_pkg::point_pair_type  pop_data,
   output logic                      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   srpe_pkg::point_pair_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("request popped from empty queue");

endmodule

`default_nettype wire

/* src/srpe_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module srpe_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  srpe_pkg::cfg_type                     cfg,
   input  wire                                   q_empty,
   input  srpe_pkg::point_pair_type              q_data,
   output logic                                  q_pop,
   output logic                                  empty,
   input  wire                                   pop,
   output logic signed [srpe_pkg::POINT_X_W-1:0] point_x,
   output logic [srpe_pkg::POINT_Y_W-1:0]        point_y,
   output logic [srpe_pkg::PIX_W-1:0]            pressure,
   output logic [srpe_pkg::WIDTH_W-1:0]          stroke_width,
   output logic                                  at_row_end,
   output logic                                  last_of_run
);

   localparam int STEP_W = $clog2(srpe_pkg::DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_LOAD = 3'b100
   } back_state_type;

   back_state_type                  state_ff, state_in;
   srpe_pkg::point_pair_type        pair_ff, pair_in;
   logic                            phase_ff, phase_in;   // 0 held point, 1 row-end point
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [srpe_pkg::SHADE_W-1:0]    rem_ff, rem_in;
   logic [srpe_pkg::PIX_W-1:0]      quo_ff, quo_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [srpe_pkg::POINT_X_W-1:0] x_ff, x_in;
   logic [srpe_pkg::POINT_Y_W-1:0]  y_ff, y_in;
   logic [srpe_pkg::PIX_W-1:0]      pr_ff, pr_in;
   logic [srpe_pkg::WIDTH_W-1:0]    wd_ff, wd_in;
   logic                            end_ff, end_in;
   logic                            last_ff, last_in;

   logic                            slot_free;
   logic                            start;
   logic                            load;
   logic [srpe_pkg::SHADE_W-1:0]    start_shade;
   logic [srpe_pkg::LEVEL_W-1:0]    start_diff;
   logic [srpe_pkg::PROD_W:0]       start_num_full;
   logic [srpe_pkg::PROD_W-1:0]     start_num;
   logic [srpe_pkg::SHADE_W:0]      trial;
   logic                            trial_ge;
   logic [srpe_pkg::COORD_W-1:0]    pt_col;
   logic [srpe_pkg::COORD_W-1:0]    pt_row;
   logic [srpe_pkg::SHADE_W-1:0]    pt_shade;

   assign slot_free = !rsp_valid_ff || pop;

   // dividend 255*(L-s), zero when the shade is out of range for L
   assign start_shade    = (state_ff == ST_IDLE)
                           ? (q_data.has_held ? q_data.held_shade : q_data.cur_shade)
                           : pair_ff.cur_shade;
   assign start_diff     = cfg.levels - srpe_pkg::LEVEL_W'(start_shade);
   assign start_num_full = {start_diff, 8'b0} - (srpe_pkg::PROD_W+1)'(start_diff);
   assign start_num      = (srpe_pkg::LEVEL_W'(start_shade) < cfg.levels)
                           ? start_num_full[srpe_pkg::PROD_W-1:0] : '0;

   // restoring division by L, one quotient bit a cycle
   assign trial    = {rem_ff, quo_ff[srpe_pkg::PIX_W-1]};
   assign trial_ge = (trial >= cfg.levels);

   assign pt_col   = phase_ff ? pair_ff.cur_column : pair_ff.held_column;
   assign pt_row   = phase_ff ? pair_ff.cur_row : pair_ff.held_row;
   assign pt_shade = phase_ff ? pair_ff.cur_shade : pair_ff.held_shade;

   always_comb begin
      state_in = state_ff;
      pair_in  = pair_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      q_pop    = 1'b0;
      start    = 1'b0;
      load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               pair_in  = q_data;
               phase_in = !q_data.has_held;
               start    = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? srpe_pkg::SHADE_W'(trial - cfg.levels)
                               : trial[srpe_pkg::SHADE_W-1:0];
            quo_in  = {quo_ff[srpe_pkg::PIX_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(srpe_pkg::DIV_STEPS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               load = 1'b1;
               if (!phase_ff && pair_ff.has_cur) begin
                  phase_in = 1'b1;
                  start    = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start) begin
         rem_in  = start_num[srpe_pkg::PROD_W-1:8];
         quo_in  = start_num[7:0];
         step_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !pop;
      x_in    = x_ff;
      y_in    = y_ff;
      pr_in   = pr_ff;
      wd_in   = wd_ff;
      end_in  = end_ff;
      last_in = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         x_in    = $signed(srpe_pkg::POINT_X_W'(pt_col) + $unsigned(cfg.offset_x));
         y_in    = srpe_pkg::POINT_Y_W'(pt_row) + srpe_pkg::POINT_Y_W'(cfg.offset_y);
         pr_in   = quo_ff;
         wd_in   = (srpe_pkg::LEVEL_W'(pt_shade) == cfg.levels - 1'b1)
                   ? srpe_pkg::WIDTH_LIGHTEST : srpe_pkg::WIDTH_STROKE;
         end_in  = phase_ff;
         last_in = phase_ff || !pair_ff.has_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pair_ff  <= pair_in;
      phase_ff <= phase_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      pr_ff    <= pr_in;
      wd_ff    <= wd_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   assign empty        = !rsp_valid_ff;
   assign point_x      = x_ff;
   assign point_y      = y_ff;
   assign pressure     = pr_ff;
   assign stroke_width = wd_ff;
   assign at_row_end   = end_ff;
   assign last_of_run  = last_ff;

   a_div_ends_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == STEP_W'(srpe_pkg::DIV_STEPS - 1))
      |=> (state_ff == ST_LOAD))
      else $error("divider did not finish after its fixed step count");

   a_no_empty_request: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_data.has_held || q_data.has_cur))
      else $error("queued request carries no point");

   a_row_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && end_ff) |-> last_ff)
      else $error("row-end point not marked last of run");

endmodule

`default_nettype wire

/* src/shade_run_point_extractor_unit.sv */
// Shade-run point extractor. Pixels (gray, alpha, column, row, row_end) go in through a
// push/full queue port and stroke points come out through an empty/pop port; each pixel gives
// zero, one or two points. The front end takes a pixel every cycle while the request queue
// has room: two stages blend on white and quantise to a shade, then compare against the held
// pixel and the last emitted shade. The back end builds points one at a time, each through a
// start, the eight-step pressure divider and a load, and takes no new request until the last
// point of the current one is loaded. QUEUE_DEPTH sets how many pending requests may queue
// between the two halves. Configuration is written through csr_valid/csr_ready (always
// ready); the user must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module shade_run_point_extractor_unit #(
   parameter int QUEUE_DEPTH = srpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   push,
   output logic                                  full,
   input  wire  [srpe_pkg::PIX_W-1:0]            req_gray_level,
   input  wire  [srpe_pkg::PIX_W-1:0]            req_alpha,
   input  wire  [srpe_pkg::COORD_W-1:0]          req_column,
   input  wire  [srpe_pkg::COORD_W-1:0]          req_row,
   input  wire                                   req_row_end,
   output logic                                  empty,
   input  wire                                   pop,
   output logic signed [srpe_pkg::POINT_X_W-1:0] rsp_point_x,
   output logic [srpe_pkg::POINT_Y_W-1:0]        rsp_point_y,
   output logic [srpe_pkg::PIX_W-1:0]            rsp_pressure,
   output logic [srpe_pkg::WIDTH_W-1:0]          rsp_stroke_width,
   output logic                                  rsp_at_row_end,
   output logic                                  rsp_last_of_run,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [srpe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [srpe_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [srpe_pkg::LEVEL_W-1:0]         levels_ff, levels_in;
   logic signed [srpe_pkg::OFFSET_W-1:0] offset_x_ff, offset_x_in;
   logic [srpe_pkg::OFFSET_W-1:0]        offset_y_ff, offset_y_in;

   srpe_pkg::cfg_type         cfg;
   srpe_pkg::point_pair_type  q_push_data;
   srpe_pkg::point_pair_type  q_pop_data;
   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      levels_in   = levels_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      if (csr_valid) begin
         case (csr_index)
            srpe_pkg::CSR_SHADE_LEVELS: levels_in   = csr_data[srpe_pkg::LEVEL_W-1:0];
            srpe_pkg::CSR_OFFSET_X:     offset_x_in = $signed(csr_data);
            srpe_pkg::CSR_OFFSET_Y:     offset_y_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff   <= srpe_pkg::LEVELS_RESET;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else begin
         levels_ff   <= levels_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
      end
   end

   // zero shades counts as one, anything above 256 as 256
   always_comb begin
      if (levels_ff == '0) begin
         cfg.levels = srpe_pkg::LEVELS_MIN;
      end else if (levels_ff > srpe_pkg::LEVELS_MAX) begin
         cfg.levels = srpe_pkg::LEVELS_MAX;
      end else begin
         cfg.levels = levels_ff;
      end
      cfg.offset_x = offset_x_ff;
      cfg.offset_y = offset_y_ff;
   end

   srpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .gray_level (req_gray_level),
      .alpha      (req_alpha),
      .column     (req_column),
      .row        (req_row),
      .row_end    (req_row_end),
      .levels     (cfg.levels),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   srpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   srpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_empty      (q_empty),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .point_x      (rsp_point_x),
      .point_y      (rsp_point_y),
      .pressure     (rsp_pressure),
      .stroke_width (rsp_stroke_width),
      .at_row_end   (rsp_at_row_end),
      .last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire
